[hdl/slsu_pkg.sv]
// Package with the constants, types and controller states of the sprite line scan unit.
package slsu_pkg;

  localparam int ENTRIES      = 40;
  localparam int LINE_LIMIT   = 10;
  localparam int Y_OFFSET     = 16;
  localparam int SHORT_HEIGHT = 8;
  localparam int TALL_HEIGHT  = 16;

  localparam int SLOT_W  = 6;
  localparam int BYTE_W  = 8;
  localparam int INDEX_W = 6;
  localparam int HITS_W  = 4;
  localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(LINE_LIMIT + 1);
  localparam int CMP_W   = 10;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_SCAN  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } slsu_state_t;

  typedef struct packed {
    logic write;
    logic load_scan;
    logic issue;
    logic finish;
  } slsu_cmd_t;

  typedef struct packed {
    logic addr_last;
    logic limit_reached;
  } slsu_sts_t;

endpackage

[hdl/slsu_ctrl.sv]
// Controller state machine that sequences writes and scans of the sprite table.
module slsu_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              kind,
  input  slsu_pkg::slsu_sts_t sts,
  output slsu_pkg::slsu_cmd_t cmd,
  output logic              busy
);
  import slsu_pkg::*;

  slsu_state_t state;
  slsu_state_t state_next;
  logic        accept;

  assign accept = start && (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && (kind == KIND_SCAN)) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.addr_last || sts.limit_reached) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state)
      ST_IDLE: begin
        busy          = 1'b0;
        cmd.write     = accept && (kind == KIND_WRITE);
        cmd.load_scan = accept && (kind == KIND_SCAN);
      end
      ST_SCAN: begin
        cmd.issue = !sts.limit_reached;
      end
      ST_DRAIN: begin
        cmd = '0;
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

[hdl/slsu_datapath.sv]
// Datapath with the position store, the range compare and the held-back result register.
module slsu_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  slsu_pkg::slsu_cmd_t         cmd,
  output slsu_pkg::slsu_sts_t         sts,
  input  logic [slsu_pkg::SLOT_W-1:0] slot,
  input  logic [slsu_pkg::BYTE_W-1:0] y_byte,
  input  logic [7:0]                  line_y,
  input  logic                        tall_sprites,
  output logic                        strobe,
  output logic [slsu_pkg::INDEX_W-1:0] entry_found,
  output logic                        hit,
  output logic                        last_of_run,
  output logic [slsu_pkg::HITS_W-1:0] hits_so_far
);
  import slsu_pkg::*;

  logic [BYTE_W-1:0]  mem [ENTRIES];
  logic [ENTRIES-1:0] vld;
  logic [ADDR_W-1:0]  addr;
  logic [BYTE_W-1:0]  rd_data;
  logic               rd_ok;
  logic               cmp_en;
  logic [ADDR_W-1:0]  cmp_idx;
  logic [7:0]         line_q;
  logic               tall_q;
  logic [CNT_W-1:0]   cnt;
  logic               pend_valid;
  logic [ADDR_W-1:0]  pend_idx;
  logic [CNT_W-1:0]   pend_cnt;
  logic               slot_ok;
  logic [BYTE_W-1:0]  cur_byte;
  logic [CMP_W-1:0]   line_ext;
  logic [CMP_W-1:0]   bot_ext;
  logic               in_range;
  logic               match;

  assign slot_ok = {1'b0, slot} < (SLOT_W + 1)'(ENTRIES);

  always_ff @(posedge clk) begin
    if (cmd.write && slot_ok) begin
      mem[slot[ADDR_W-1:0]] <= y_byte;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      rd_ok <= 1'b0;
    end else begin
      rd_ok <= vld[addr];
      if (cmd.write && slot_ok) begin
        vld[slot[ADDR_W-1:0]] <= 1'b1;
      end
    end
  end

  assign cur_byte = rd_ok ? rd_data : '0;

  // The line lies in the sprite when byte <= line + offset < byte + height.
  assign line_ext = CMP_W'(line_q) + CMP_W'(Y_OFFSET);
  assign bot_ext  = CMP_W'(cur_byte) +
                    (tall_q ? CMP_W'(TALL_HEIGHT) : CMP_W'(SHORT_HEIGHT));
  assign in_range = (line_ext >= CMP_W'(cur_byte)) && (line_ext < bot_ext);
  assign match    = cmp_en && in_range && !sts.limit_reached;

  assign sts.addr_last     = addr == ADDR_W'(ENTRIES - 1);
  assign sts.limit_reached = cnt == CNT_W'(LINE_LIMIT);

  always_ff @(posedge clk) begin
    if (cmd.load_scan) begin
      line_q <= line_y;
      tall_q <= tall_sprites;
    end
    cmp_idx <= addr;
    if (match) begin
      pend_idx <= cmp_idx;
      pend_cnt <= cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      addr       <= '0;
      cmp_en     <= 1'b0;
      cnt        <= '0;
      pend_valid <= 1'b0;
    end else begin
      cmp_en <= cmd.issue;
      if (cmd.load_scan) begin
        addr       <= '0;
        cnt        <= '0;
        pend_valid <= 1'b0;
      end else begin
        if (cmd.issue) begin
          addr <= addr + ADDR_W'(1);
        end
        if (match) begin
          cnt        <= cnt + CNT_W'(1);
          pend_valid <= 1'b1;
        end
      end
    end
  end

  // A match is held back until the next match or the end of the scan shows whether it is the last.
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= (match && pend_valid) || cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish && !pend_valid) begin
      entry_found <= '0;
      hit         <= 1'b0;
      last_of_run <= 1'b1;
      hits_so_far <= '0;
    end else begin
      entry_found <= INDEX_W'(pend_idx);
      hit         <= 1'b1;
      last_of_run <= cmd.finish;
      hits_so_far <= HITS_W'(pend_cnt);
    end
  end

endmodule

[hdl/sprite_line_scan_unit.sv]
// Top level of the sprite line scan unit.
//
//   channel | transfer                          | fields
//   --------+-----------------------------------+-----------------------------------------
//   input   | start high and busy low at a edge | kind, slot, y_byte, line_y, tall_sprites
//   result  | strobe high for one cycle         | entry_found, hit, last_of_run, hits_so_far
//
// A write transfer leaves busy low.
// A scan reads one table entry per cycle and holds busy through the whole table,
// less of it when the line limit is reached early.
// Each match is held back until the next match or the end of the scan, so a result appears
// in the cycle after the following match, and the last result in the cycle in which busy falls.
// Reset clears the position table through per-entry valid bits.
// The receiver cannot stall, so every result is shown for exactly one cycle.
module sprite_line_scan_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         kind,
  input  logic [slsu_pkg::SLOT_W-1:0]  slot,
  input  logic [slsu_pkg::BYTE_W-1:0]  y_byte,
  input  logic [7:0]                   line_y,
  input  logic                         tall_sprites,
  output logic                         strobe,
  output logic [slsu_pkg::INDEX_W-1:0] entry_found,
  output logic                         hit,
  output logic                         last_of_run,
  output logic [slsu_pkg::HITS_W-1:0]  hits_so_far
);
  import slsu_pkg::*;

  slsu_cmd_t cmd;
  slsu_sts_t sts;

  slsu_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .kind  (kind),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  slsu_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .slot         (slot),
    .y_byte       (y_byte),
    .line_y       (line_y),
    .tall_sprites (tall_sprites),
    .strobe       (strobe),
    .entry_found  (entry_found),
    .hit          (hit),
    .last_of_run  (last_of_run),
    .hits_so_far  (hits_so_far)
  );

endmodule

[hdl/slsu_checker.sv]
// Port-level checker for the sprite line scan unit, bound to the top level.
module slsu_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         start,
  input logic                         busy,
  input logic                         kind,
  input logic                         strobe,
  input logic                         hit,
  input logic                         last_of_run,
  input logic [slsu_pkg::HITS_W-1:0]  hits_so_far
);
  import slsu_pkg::*;

  a_no_hit_shape: assert property (@(posedge clk) disable iff (rst)
    strobe && !hit |-> last_of_run && (hits_so_far == '0))
    else $error("A no-hit result is not a lone final result with a zero count.");

  a_hit_count: assert property (@(posedge clk) disable iff (rst)
    strobe && hit |-> (hits_so_far != '0) && (hits_so_far <= HITS_W'(LINE_LIMIT)))
    else $error("A hit result carries a count outside one to the line limit.");

  a_write_quick: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (kind == KIND_WRITE) |=> !busy)
    else $error("A write transfer left the unit busy.");

  a_more_follows: assert property (@(posedge clk) disable iff (rst)
    strobe && !last_of_run |-> busy)
    else $error("A result that is not the last appeared after the scan had ended.");

  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start && (kind == KIND_SCAN)))
    else $error("Busy rose without an accepted scan transfer.");

endmodule

bind sprite_line_scan_unit slsu_checker u_slsu_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .kind        (kind),
  .strobe      (strobe),
  .hit         (hit),
  .last_of_run (last_of_run),
  .hits_so_far (hits_so_far)
);
